// ===== rtl/sst_pkg.sv =====
// Shared types, constants and helpers for the separation steering block.
package sst_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_STEPS = 18;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_GAIN   = 2'd1;
    localparam logic [1:0] CFG_THRESH = 2'd2;

    localparam logic [15:0] RADIUS_RST = 16'd1000;
    localparam logic [15:0] GAIN_RST   = 16'd256;
    localparam logic [23:0] THRESH_RST = 24'd327680;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_SQR,
        S_TEST,
        S_DIV,
        S_ACC,
        S_SCALE,
        S_MAG,
        S_CMP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic diff;
        logic sqr;
        logic div_start;
        logic div_step;
        logic acc;
        logic scale;
        logic mag;
        logic cmp;
        logic out_load;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic div_done;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 32'sh7fffffff;
        if (v < -34'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// ===== rtl/sst_ctrl.sv =====
// Controller sequencing one agent transaction through the datapath.
module sst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_last,
    input  logic              i_out_busy,
    input  sst_pkg::t_status  i_status,
    output sst_pkg::t_cmd     o_cmd
);
    import sst_pkg::*;

    t_state r_state, n_state;
    logic   r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_last     = i_last;
                    n_state    = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_SQR;
            end
            S_SQR: begin
                o_cmd.sqr = 1'b1;
                n_state   = S_TEST;
            end
            S_TEST: begin
                if (i_status.hit) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = r_last ? S_SCALE : S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = r_last ? S_SCALE : S_IDLE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_MAG;
            end
            S_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!i_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    ap_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    ap_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !o_cmd.div_step && !o_cmd.acc) else $error("cmd overlap");
    ap_load_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DIFF)) else $error("load not followed by diff");
`endif
endmodule

// ===== rtl/sst_datapath.sv =====
// Datapath: offsets, squared distance, per-axis dividers, accumulator, scaling, threshold.
module sst_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sst_pkg::t_cmd     i_cmd,
    output sst_pkg::t_status  o_status,
    input  logic [95:0]       i_data,
    input  logic [15:0]       i_radius,
    input  logic [15:0]       i_gain,
    input  logic [23:0]       i_thresh,
    output logic [31:0]       o_vx,
    output logic [31:0]       o_vy,
    output logic [31:0]       o_vz
);
    import sst_pkg::*;

    logic signed [15:0] r_pos [6];
    logic signed [16:0] r_d [3];
    logic [35:0] r_r2;
    logic [31:0] r_rad2;
    logic signed [31:0] r_sum [3];
    logic signed [49:0] r_prod [3];
    logic [31:0] r_v [3];
    logic [0:0] r_neg [3];
    logic r_big;
    logic [49:0] r_m2;
    logic [35:0] r_rem [3];
    logic [32:0] r_num [3];
    logic [16:0] r_q [3];
    logic [4:0] r_cnt;

    assign o_status.hit = (r_r2 != 36'd0) && (r_r2 < {4'd0, r_rad2});
    assign o_status.div_done = (r_cnt == 5'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        logic [36:0] t;
        logic [41:0] sc;
        logic [15:0] am;
        if (i_cmd.load) begin
            for (int k = 0; k < 6; k++) r_pos[k] <= i_data[16*k +: 16];
            r_rad2 <= i_radius * i_radius;
        end
        if (i_cmd.diff)
            for (int k = 0; k < 3; k++)
                r_d[k] <= 17'(r_pos[k+3]) - 17'(r_pos[k]);
        if (i_cmd.sqr)
            r_r2 <= 36'(34'(r_d[0] * r_d[0])) + 36'(34'(r_d[1] * r_d[1]))
                  + 36'(34'(r_d[2] * r_d[2]));
        // restoring divide, one quotient bit per axis per cycle
        if (i_cmd.div_start) begin
            r_cnt <= '0;
            for (int k = 0; k < 3; k++) begin
                am = r_d[k][16] ? 16'(-r_d[k]) : r_d[k][15:0];
                // quotient fits in the step count: start from the numerator's top bits
                r_num[k] <= {am[1:0], 31'd0};
                r_rem[k] <= {22'd0, am[15:2]};
                r_q[k]   <= '0;
            end
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 5'd1;
            for (int k = 0; k < 3; k++) begin
                t = {r_rem[k], r_num[k][32]};
                r_num[k] <= {r_num[k][31:0], 1'b0};
                if (t >= {1'b0, r_r2}) begin
                    r_rem[k] <= 36'(t - {1'b0, r_r2});
                    r_q[k]   <= {r_q[k][15:0], 1'b1};
                end else begin
                    r_rem[k] <= t[35:0];
                    r_q[k]   <= {r_q[k][15:0], 1'b0};
                end
            end
        end
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < 3; k++) r_sum[k] <= '0;
        end else if (i_cmd.acc) begin
            for (int k = 0; k < 3; k++)
                r_sum[k] <= sat32(34'(r_sum[k]) + (r_d[k][16] ?
                    -34'(r_q[k]) : 34'(r_q[k])));
        end
        if (i_cmd.scale)
            for (int k = 0; k < 3; k++)
                r_prod[k] <= 50'(r_sum[k]) * 50'($signed({1'b0, i_gain}));
        if (i_cmd.mag) begin
            r_big <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                sc = r_prod[k][49] ? 42'((-r_prod[k]) >> (FRAC_BITS - 8))
                                    : 42'(r_prod[k] >> (FRAC_BITS - 8));
                r_neg[k] <= r_prod[k][49];
                r_v[k] <= (sc[41:31] != 11'd0) ?
                    (r_prod[k][49] ? 32'h80000000 : 32'h7fffffff) : sc[31:0];
                if (sc[41:24] != 18'd0) r_big <= 1'b1;
            end
        end
        if (i_cmd.cmp) begin
            r_m2 <= 50'(r_v[0][23:0] * r_v[0][23:0]) + 50'(r_v[1][23:0] * r_v[1][23:0])
                  + 50'(r_v[2][23:0] * r_v[2][23:0]);
        end
    end

    logic small_now;
    assign small_now = !r_big && (r_m2 < 50'(i_thresh * i_thresh));

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_vx <= small_now ? '0 : (r_neg[0] ? (r_v[0] == 32'h80000000 ? r_v[0]
                                                  : -r_v[0]) : r_v[0]);
            o_vy <= small_now ? '0 : (r_neg[1] ? (r_v[1] == 32'h80000000 ? r_v[1]
                                                  : -r_v[1]) : r_v[1]);
            o_vz <= small_now ? '0 : (r_neg[2] ? (r_v[2] == 32'h80000000 ? r_v[2]
                                                  : -r_v[2]) : r_v[2]);
        end
    end

`ifndef SYNTHESIS
    ap_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_sum[0] == 0 && r_sum[1] == 0 && r_sum[2] == 0))
        else $error("accumulator not cleared");
    ap_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> (r_cnt == 5'd0)) else $error("divider count");
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.out_load |=> $stable(o_vx)) else $error("output moved");
`endif
endmodule

// ===== rtl/separation_steering_unit.sv =====
// Separation steering unit: top level joining controller and datapath.
//
// Usage: each s_axis transaction carries the actor position and one agent
// position (tdata) with tlast marking the final agent of the set. Agents
// inside the neighborhood radius add offset/r^2 to a three-axis sum. On the
// tlast transaction the sum is scaled by the gain, zeroed if weaker than
// the threshold, saturated, and one m_axis transaction follows.
// Agents outside the radius pass difference, square and radius test; those
// inside also run the 18-step restoring divide and accumulate; the last adds
// scale, magnitude and compare; agents go one at a time. Reset (synchronous,
// active low) clears the sum and restores the register defaults. When the
// receiver stalls, the result is held in the output register; further agents
// are still accepted until the next result is due. The user must write the
// registers (i_cfg_we / i_cfg_idx / i_cfg_data) only while idle; unenforced.
module separation_steering_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // actor_x, actor_y, actor_z, agent_x, agent_y, agent_z (16 bit each)
    input  logic [95:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // vel_x, vel_y, vel_z (32 bit each)
    output logic [95:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);
    import sst_pkg::*;

    logic [15:0] r_radius, r_gain;
    logic [23:0] r_thresh;
    logic        r_ovalid;
    t_cmd        cmd;
    t_status     status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_gain   <= GAIN_RST;
            r_thresh <= THRESH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS: r_radius <= i_cfg_data[15:0];
                CFG_GAIN:   r_gain   <= i_cfg_data[15:0];
                CFG_THRESH: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (cmd.out_load) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end
    assign m_axis_tvalid = r_ovalid;

    sst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_last     (s_axis_tlast),
        .i_out_busy (r_ovalid && !m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sst_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_data   (s_axis_tdata),
        .i_radius (r_radius),
        .i_gain   (r_gain),
        .i_thresh (r_thresh),
        .o_vx     (m_axis_tdata[31:0]),
        .o_vy     (m_axis_tdata[63:32]),
        .o_vz     (m_axis_tdata[95:64])
    );

`ifndef SYNTHESIS
    ap_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result lost");
    ap_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    ap_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(r_ovalid && !m_axis_tready)) else $error("overwrite");
`endif
endmodule
